>>> sv/snt_pkg.sv
`default_nettype none

package snt_pkg;

  localparam int CAPACITY   = 16;
  localparam int NAME_BYTES = 8;

  localparam int KEY_W   = 64;
  localparam int OP_W    = 2;
  localparam int IDX_W   = 4;
  localparam int STAT_W  = 2;
  localparam int ENTRY_W = 5;
  localparam int COUNT_W = $clog2(CAPACITY + 1);
  localparam int RD_W    = (COUNT_W > IDX_W) ? COUNT_W : IDX_W;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_READ   = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;

  typedef logic [KEY_W-1:0] key_t;

  typedef struct packed {
    logic insert;
    logic valid;
  } cell_ctl_t;

  // keep the top name bytes, zero everything from the first nul on
  function automatic key_t normalize_key(input key_t k);
    key_t       res;
    logic       keep;
    logic [7:0] b;
    res  = '0;
    keep = 1'b1;
    for (int i = 0; i < 8; i++) begin
      b = k[KEY_W-1-8*i -: 8];
      if (b == 8'd0 || i >= NAME_BYTES) begin
        keep = 1'b0;
      end
      res[KEY_W-1-8*i -: 8] = keep ? b : 8'd0;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

>>> sv/snt_cell.sv
`default_nettype none

module snt_cell
  import snt_pkg::*;
(
  input  wire logic      clk,
  input  wire cell_ctl_t ctl,
  input  wire key_t      new_key,
  input  wire logic      left_le,
  input  wire key_t      left_key,
  output logic           le,
  output key_t           key
);

  // held key is valid and not above the incoming key
  assign le = ctl.valid && (key <= new_key);

  always_ff @(posedge clk) begin
    if (ctl.insert && !le) begin
      key <= left_le ? new_key : left_key;
    end
  end

endmodule

`default_nettype wire

>>> sv/sorted_name_table_unit.sv
// result: registered when the item is accepted; out_valid rises in the next cycle
// throughput: one item per cycle unless the output stalls; each cell compares
//   its key with the incoming key and shifts right in that same cycle
// reset: clears the held entry count and the output valid; cell keys are
//   not reset and are only read below the count
`default_nettype none

module sorted_name_table_unit
  import snt_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [OP_W-1:0]     op,
  input  wire logic [KEY_W-1:0]    key_in,
  input  wire logic [IDX_W-1:0]    read_index,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [STAT_W-1:0]        status,
  output logic [ENTRY_W-1:0]       entry_count,
  output logic [KEY_W-1:0]         key_out
);

  logic [COUNT_W-1:0] held_count;
  logic [COUNT_W-1:0] held_count_next;
  logic               in_accept;
  logic               full;
  logic               do_insert;
  key_t               norm_key;
  key_t               cell_key [CAPACITY];
  logic               cell_le  [CAPACITY];
  logic [RD_W-1:0]    rd_ext;
  logic               read_ok;
  key_t               read_key;
  logic [STAT_W-1:0]  status_next;
  key_t               key_out_next;

  assign in_stall  = out_valid && out_stall;
  assign in_accept = in_valid && !in_stall;
  assign full      = (held_count == COUNT_W'(CAPACITY));
  assign do_insert = in_accept && (op == OP_INSERT) && !full;
  assign norm_key  = normalize_key(key_in);

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    cell_ctl_t ctl;
    logic      left_le;
    key_t      left_key;

    assign ctl.insert = do_insert;
    assign ctl.valid  = (COUNT_W'(i) < held_count);

    if (i == 0) begin : g_head
      assign left_le  = 1'b1;
      assign left_key = norm_key;
    end else begin : g_body
      assign left_le  = cell_le[i-1];
      assign left_key = cell_key[i-1];
    end

    snt_cell u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .new_key  (norm_key),
      .left_le  (left_le),
      .left_key (left_key),
      .le       (cell_le[i]),
      .key      (cell_key[i])
    );
  end

  assign rd_ext  = RD_W'(read_index);
  assign read_ok = (rd_ext < RD_W'(held_count)) && (rd_ext < RD_W'(CAPACITY));

  always_comb begin
    read_key = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (rd_ext == RD_W'(i)) begin
        read_key = cell_key[i];
      end
    end
  end

  always_comb begin
    held_count_next = held_count;
    status_next     = ST_OK;
    key_out_next    = '0;
    unique case (op)
      OP_INSERT: begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          held_count_next = held_count + COUNT_W'(1);
        end
      end
      OP_READ: begin
        if (read_ok) begin
          key_out_next = read_key;
        end else begin
          status_next = ST_RANGE;
        end
      end
      OP_CLEAR: begin
        held_count_next = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (in_accept) begin
        held_count <= held_count_next;
        out_valid  <= 1'b1;
      end else if (!out_stall) begin
        out_valid  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      status      <= status_next;
      entry_count <= ENTRY_W'(held_count_next);
      key_out     <= key_out_next;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    held_count <= COUNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    in_accept && op == OP_CLEAR |=> held_count == '0)
    else $error("clear did not empty the table");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    do_insert |=> held_count == $past(held_count) + COUNT_W'(1))
    else $error("insert did not add one entry");

  a_item_result: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> out_valid && entry_count == ENTRY_W'(held_count))
    else $error("result missing or count mismatch");
`endif

endmodule

`default_nettype wire
